@@ rtl/mdks_pkg.sv @@
// Shared types and constants for the minimum-distance keypoint selector.
// Used by the front classifier, the item queue, the back engine and the top level.
package mdks_pkg;

  // Input opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_MATCHED = 2'd1;
  localparam logic [1:0] OP_NEW     = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_ACCEPTED   = 3'd0;
  localparam logic [2:0] STAT_FRAME      = 3'd1;
  localparam logic [2:0] STAT_FULL       = 3'd2;
  localparam logic [2:0] STAT_DUPLICATE  = 3'd3;
  localparam logic [2:0] STAT_OUTSIDE    = 3'd4;
  localparam logic [2:0] STAT_MASKED     = 3'd5;
  localparam logic [2:0] STAT_TOO_CLOSE  = 3'd6;
  localparam logic [2:0] STAT_REFILL_OFF = 3'd7;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MIN_DISTANCE  = 3'd0;
  localparam logic [2:0] REG_MAX_FEATURES  = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_REFILL_ENABLE = 3'd4;

  // Mask bytes above this value reject a candidate
  localparam logic [7:0] MASK_LIMIT = 8'd127;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]  min_distance;
    logic [8:0]  max_features;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        refill_enable;
  } cfg_t;

  // Classified candidate handed from front to back
  typedef struct packed {
    logic               is_start;
    logic               is_new;
    logic signed [17:0] x_pos;
    logic signed [17:0] y_pos;
    logic [9:0]         cand_index;
    logic [31:0]        prior_id;
    logic               refill_off;
    logic               outside;
    logic               masked;
  } cand_rec_t;

endpackage

@@ rtl/mdks_ifs.sv @@
// Valid/ready channel interfaces for candidate beats and result beats.
// Standalone; payload widths follow the selector's field definitions.
interface mdks_cand_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [17:0] x_pos;
  logic signed [17:0] y_pos;
  logic [9:0]         cand_index;
  logic               mask_present;
  logic [7:0]         mask_byte;
  logic [31:0]        prior_id;

  modport source (
    output valid, opcode, x_pos, y_pos, cand_index, mask_present, mask_byte, prior_id,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_pos, y_pos, cand_index, mask_present, mask_byte, prior_id,
    output ready
  );
endinterface

interface mdks_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] track_id;
  logic [8:0]  accepted_count;

  modport source (output valid, status, track_id, accepted_count, input ready);
  modport sink   (input  valid, status, track_id, accepted_count, output ready);
endinterface

@@ rtl/mdks_front.sv @@
// Front classifier: accepts candidate beats, rounds positions, checks bounds,
// mask and refill, and pushes a classified record. Depends on mdks_pkg, mdks_ifs.
module mdks_front (
  mdks_cand_if.sink             cand,
  input  mdks_pkg::cfg_t        cfg,
  input  logic                  accept_en,
  input  logic                  q_full,
  output logic                  q_push,
  output mdks_pkg::cand_rec_t   q_wdata
);

  // Round Q4 half away from zero, report pixel outside [0, limit)
  function automatic logic axis_outside(input logic signed [17:0] v,
                                        input logic [12:0] limit);
    logic        neg;
    logic [17:0] mag;
    logic [17:0] rsum;
    logic [13:0] rmag;
    begin
      neg  = v[17];
      mag  = neg ? (~v + 18'd1) : v;
      rsum = mag + 18'd8;
      rmag = rsum[17:4];
      axis_outside = (neg && (rmag != 14'd0)) || (rmag >= {1'b0, limit});
    end
  endfunction

  logic beat;

  // Hold off while the queue is full or the index map is still clearing after reset
  assign cand.ready = accept_en && !q_full;
  assign beat       = cand.valid && cand.ready;

  // Drop unused opcodes, push everything else
  assign q_push = beat && (cand.opcode != mdks_pkg::OP_UNUSED);

  // Classify the candidate
  always_comb begin
    q_wdata.is_start   = (cand.opcode == mdks_pkg::OP_START);
    q_wdata.is_new     = (cand.opcode == mdks_pkg::OP_NEW);
    q_wdata.x_pos      = cand.x_pos;
    q_wdata.y_pos      = cand.y_pos;
    q_wdata.cand_index = cand.cand_index;
    q_wdata.prior_id   = cand.prior_id;
    q_wdata.refill_off = (cand.opcode == mdks_pkg::OP_NEW) && !cfg.refill_enable;
    q_wdata.outside    = axis_outside(cand.x_pos, cfg.image_width) ||
                         axis_outside(cand.y_pos, cfg.image_height);
    q_wdata.masked     = cand.mask_present && (cand.mask_byte > mdks_pkg::MASK_LIMIT);
  end

endmodule

@@ rtl/mdks_queue.sv @@
// Short FIFO of classified candidate records between front and back.
// Depends on mdks_pkg for the record type and depth.
module mdks_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mdks_pkg::cand_rec_t  wdata,
  input  logic                 pop,
  output logic                 valid,
  output logic                 full,
  output mdks_pkg::cand_rec_t  rdata
);

  localparam int PW = (mdks_pkg::QUEUE_DEPTH > 1) ? $clog2(mdks_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mdks_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(mdks_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(mdks_pkg::QUEUE_DEPTH);

  mdks_pkg::cand_rec_t entries [mdks_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign valid = (fill != '0);
  assign full  = (fill == DEPTH_C);
  assign rdata = entries[rd_ptr];

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ rtl/mdks_back.sv @@
// Back engine: index map clearing and lookup, refill/capacity/duplicate/bounds/mask checks,
// distance scan over accepted list, commit, result register. Depends on mdks_pkg, mdks_ifs.
module mdks_back #(
  parameter int MAX_FEATURES = 256,
  parameter int INDEX_SLOTS  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mdks_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  mdks_pkg::cand_rec_t  q_head,
  output logic                 q_pop,
  output logic                 init_done,
  mdks_result_if.source        result
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int KW = (INDEX_SLOTS > 1) ? $clog2(INDEX_SLOTS) : 1;
  localparam logic [12:0]   FEAT_LIMIT = 13'(MAX_FEATURES);
  localparam logic [14:0]   KEY_LIMIT  = 15'(INDEX_SLOTS);
  localparam logic [KW-1:0] CLR_LAST   = KW'(INDEX_SLOTS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]          state;
  mdks_pkg::cand_rec_t cur;
  logic [KW-1:0]       clr_addr;
  logic [8:0]          count;
  logic [31:0]         next_id;
  logic [23:0]         lim;
  logic [8:0]          scan_addr;

  // Accepted list and index map
  logic signed [17:0]  acc_x [MAX_FEATURES];
  logic signed [17:0]  acc_y [MAX_FEATURES];
  logic                used_mem [INDEX_SLOTS];
  logic                used_rd;

  // Scan pipeline
  logic                v1, v2, v3;
  logic signed [17:0]  rd_x, rd_y;
  logic signed [18:0]  dx, dy;
  logic signed [37:0]  sqx, sqy;
  logic [38:0]         dist_sum;
  logic                hit;

  // Result register
  logic                out_valid;
  logic [2:0]          out_status;
  logic [31:0]         out_id;
  logic [8:0]          out_count;
  logic [2:0]          res_status;
  logic [31:0]         res_id;
  logic [8:0]          res_count;

  // Control decode
  logic                clearing;
  logic                last_clear;
  logic [15:0]         idx_ext;
  logic [15:0]         count_ext;
  logic [15:0]         scan_ext;
  logic                idx_oor;
  logic                full;
  logic                chk_reject;
  logic [2:0]          chk_code;
  logic                need_scan;
  logic                scan_issue;
  logic                scan_done;
  logic                commit;
  logic                out_free;

  assign init_done  = (state != S_INIT);
  assign clearing   = (state == S_INIT) || (state == S_CLEAR);
  assign last_clear = (clr_addr == CLR_LAST);
  assign idx_ext    = {6'd0, cur.cand_index};
  assign count_ext  = {7'd0, count};
  assign scan_ext   = {7'd0, scan_addr};
  assign idx_oor    = ({5'd0, cur.cand_index} >= KEY_LIMIT);
  assign full       = (count_ext[12:0] >= {4'd0, cfg.max_features}) ||
                      (count_ext[12:0] >= FEAT_LIMIT);
  assign need_scan  = (cfg.min_distance != 8'd0) && (count != 9'd0);
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign out_free   = !out_valid || result.ready;

  // Pick the first failing check in priority order
  always_comb begin
    chk_reject = 1'b1;
    chk_code   = mdks_pkg::STAT_ACCEPTED;
    if (cur.refill_off) chk_code = mdks_pkg::STAT_REFILL_OFF;
    else if (full) chk_code = mdks_pkg::STAT_FULL;
    else if (idx_oor || used_rd) chk_code = mdks_pkg::STAT_DUPLICATE;
    else if (cur.outside) chk_code = mdks_pkg::STAT_OUTSIDE;
    else if (cur.masked) chk_code = mdks_pkg::STAT_MASKED;
    else chk_reject = 1'b0;
  end

  // Squared distance compare at the end of the scan pipeline
  assign dist_sum   = {1'b0, $unsigned(sqx)} + {1'b0, $unsigned(sqy)};
  assign hit        = (state == S_SCAN) && v3 && (dist_sum < {15'd0, lim});
  assign scan_issue = (state == S_SCAN) && (scan_addr < count);
  assign scan_done  = (state == S_SCAN) && !hit && (scan_addr == count) && !v1 && !v2 && !v3;
  assign commit     = ((state == S_CHECK) && !chk_reject && !need_scan) || scan_done;

  // Index map: one write port shared by clearing and commit, registered read
  always_ff @(posedge clk) begin
    if (clearing) used_mem[clr_addr] <= 1'b0;
    else if (commit) used_mem[idx_ext[KW-1:0]] <= 1'b1;
    used_rd <= used_mem[idx_ext[KW-1:0]];
  end

  // Accepted positions: write at the list tail, read at the scan address
  always_ff @(posedge clk) begin
    if (commit) begin
      acc_x[count_ext[AW-1:0]] <= cur.x_pos;
      acc_y[count_ext[AW-1:0]] <= cur.y_pos;
    end
    rd_x <= acc_x[scan_ext[AW-1:0]];
    rd_y <= acc_y[scan_ext[AW-1:0]];
  end

  // Difference, square, and the squared spacing limit
  always_ff @(posedge clk) begin
    dx  <= {rd_x[17], rd_x} - {cur.x_pos[17], cur.x_pos};
    dy  <= {rd_y[17], rd_y} - {cur.y_pos[17], cur.y_pos};
    sqx <= 38'(dx) * 38'(dx);
    sqy <= 38'(dy) * 38'(dy);
    lim <= 24'({cfg.min_distance, 4'd0}) * 24'({cfg.min_distance, 4'd0});
  end

  // Scan stage valids, flushed outside the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= scan_issue;
      v2 <= v1 && (state == S_SCAN);
      v3 <= v2 && (state == S_SCAN);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
      count    <= 9'd0;
      next_id  <= 32'd0;
    end else begin
      case (state)
        S_INIT: begin
          clr_addr <= clr_addr + 1'b1;
          if (last_clear) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            if (q_head.is_start) begin
              count    <= 9'd0;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (last_clear) begin
            res_status <= mdks_pkg::STAT_FRAME;
            res_id     <= 32'd0;
            res_count  <= 9'd0;
            state      <= S_FINISH;
          end
        end
        S_LOOKUP: state <= S_CHECK;
        S_CHECK: begin
          if (chk_reject) begin
            res_status <= chk_code;
            res_id     <= 32'd0;
            res_count  <= count;
            state      <= S_FINISH;
          end else if (need_scan) begin
            scan_addr <= 9'd0;
            state     <= S_SCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SCAN: begin
          if (scan_issue) scan_addr <= scan_addr + 1'b1;
          if (hit) begin
            res_status <= mdks_pkg::STAT_TOO_CLOSE;
            res_id     <= 32'd0;
            res_count  <= count;
            state      <= S_FINISH;
          end else if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // Commit an accepted candidate
      if (commit) begin
        count      <= count + 1'b1;
        res_status <= mdks_pkg::STAT_ACCEPTED;
        res_count  <= count + 1'b1;
        if (cur.is_new) begin
          next_id <= next_id + 1'b1;
          res_id  <= next_id + 1'b1;
        end else begin
          res_id <= cur.prior_id;
        end
      end
    end
  end

  // Result register: load when the slot frees, drop on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_count  <= res_count;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.track_id       = out_id;
  assign result.accepted_count = out_count;

endmodule

@@ rtl/min_distance_keypoint_selector_unit.sv @@
// Minimum-distance keypoint selector top level: APB register file, front
// classifier, record queue and back engine. Depends on mdks_pkg, mdks_ifs and submodules.
// The spacing check scans the accepted points, stopping at the first one that is too close;
// a frame start clears the whole index map before its result beat.
// Back engine: one item at a time; it pops no new record until its result is loaded.
// Reset: synchronous; the index map then clears, with input held off.
module min_distance_keypoint_selector_unit #(
  parameter int MAX_FEATURES = 256,
  parameter int INDEX_SLOTS  = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  mdks_cand_if.sink     cand,
  mdks_result_if.source result
);

  mdks_pkg::cfg_t      cfg;
  mdks_pkg::cand_rec_t q_wdata;
  mdks_pkg::cand_rec_t q_head;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  logic                q_full;
  logic                init_done;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_distance  <= 8'd0;
      cfg.max_features  <= 9'd256;
      cfg.image_width   <= 13'd640;
      cfg.image_height  <= 13'd480;
      cfg.refill_enable <= 1'b1;
    end else if (wr_en) begin
      case (paddr[4:2])
        mdks_pkg::REG_MIN_DISTANCE:  cfg.min_distance  <= pwdata[7:0];
        mdks_pkg::REG_MAX_FEATURES:  cfg.max_features  <= pwdata[8:0];
        mdks_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[12:0];
        mdks_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[12:0];
        mdks_pkg::REG_REFILL_ENABLE: cfg.refill_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      mdks_pkg::REG_MIN_DISTANCE:  prdata = {24'd0, cfg.min_distance};
      mdks_pkg::REG_MAX_FEATURES:  prdata = {23'd0, cfg.max_features};
      mdks_pkg::REG_IMAGE_WIDTH:   prdata = {19'd0, cfg.image_width};
      mdks_pkg::REG_IMAGE_HEIGHT:  prdata = {19'd0, cfg.image_height};
      mdks_pkg::REG_REFILL_ENABLE: prdata = {31'd0, cfg.refill_enable};
      default:                     prdata = 32'd0;
    endcase
  end

  mdks_front u_front (
    .cand      (cand),
    .cfg       (cfg),
    .accept_en (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mdks_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .rdata (q_head)
  );

  mdks_back #(
    .MAX_FEATURES (MAX_FEATURES),
    .INDEX_SLOTS  (INDEX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_done (init_done),
    .result    (result)
  );

endmodule
